// ===== sv/wshp_pkg.sv =====
`default_nettype none

package wshp_pkg;

    // Result status codes
    localparam logic [2:0] STATUS_OK         = 3'd0;
    localparam logic [2:0] STATUS_CLOSE      = 3'd1;
    localparam logic [2:0] STATUS_FRAGMENTED = 3'd2;
    localparam logic [2:0] STATUS_UNMASKED   = 3'd3;
    localparam logic [2:0] STATUS_NOT_BINARY = 3'd4;

    // Opcodes of the first header byte
    localparam logic [3:0] OP_CLOSE  = 4'h8;
    localparam logic [3:0] OP_BINARY = 4'h2;

    // Length codes of the second header byte
    localparam logic [6:0] LEN_CODE_EXT16 = 7'd126;

    // Header sizes in bytes
    localparam logic [3:0] HDR_LEN_SHORT = 4'd2;
    localparam logic [3:0] HDR_LEN_7     = 4'd6;
    localparam logic [3:0] HDR_LEN_16    = 4'd8;
    localparam logic [3:0] HDR_LEN_64    = 4'd14;
    localparam logic [3:0] MASK_BYTES    = 4'd4;

    // Byte positions
    localparam logic [3:0] IDX_FIRST  = 4'd0;
    localparam logic [3:0] IDX_SECOND = 4'd1;
    localparam logic [3:0] IDX_EXT    = 4'd2;

    typedef enum logic [1:0] {
        LEN_KIND_7  = 2'd0,
        LEN_KIND_16 = 2'd1,
        LEN_KIND_64 = 2'd2,
        LEN_KIND_RSV = 2'd3
    } len_kind_t;

    // Total header size for a length kind; the reserved kind acts as 64-bit.
    function automatic logic [3:0] header_total(input len_kind_t kind);
        logic [3:0] total;
        case (kind)
            LEN_KIND_7:  total = HDR_LEN_7;
            LEN_KIND_16: total = HDR_LEN_16;
            default:     total = HDR_LEN_64;
        endcase
        return total;
    endfunction

endpackage

`default_nettype wire

// ===== sv/websocket_header_parser.sv =====
`default_nettype none

// Channel  | Ports                                          | Direction
// ---------+------------------------------------------------+----------
// input    | s_valid, s_ready, s_rx_byte                    | in
// result   | m_valid, m_ready, m_status, m_payload_length,  | out
//          | m_mask_key, m_header_length                    |
//
// One header byte per cycle is taken in, set by the single decode step that
// sits between the input and result registers, unless a stalled result holds it.
// A byte goes from transfer to result through the input register, then the
// result register; bytes that end no header give no result.
// Reset (synchronous, active low) empties both registers and restarts the
// parser at the first header byte.
// A stalled result holds the decode step; the input register still takes
// one more byte, then s_ready drops until the result is taken.
module websocket_header_parser
    import wshp_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_rx_byte,

    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [2:0]       m_status,
    output logic [63:0]      m_payload_length,
    output logic [31:0]      m_mask_key,
    output logic [3:0]       m_header_length
);

    // Input byte register
    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;

    // Parser state
    logic [3:0]  byte_count_reg,   byte_count_next;
    len_kind_t   length_kind_reg,  length_kind_next;
    logic [63:0] length_accum_reg, length_accum_next;
    logic [31:0] mask_accum_reg,   mask_accum_next;

    // Result register
    logic        out_valid_reg;
    logic [2:0]  status_reg,       status_next;
    logic [63:0] payload_len_reg,  payload_len_next;
    logic [31:0] mask_key_reg,     mask_key_next;
    logic [3:0]  header_len_reg,   header_len_next;

    logic        out_free;
    logic        step;
    logic        emit;

    logic [3:0]  total;
    logic [3:0]  mask_start;
    logic [3:0]  count_inc;
    logic [7:0]  first_byte;
    logic [3:0]  opcode;
    logic [6:0]  len_code;

    // The decode step runs when a byte waits and the result slot is free.
    assign out_free = !out_valid_reg || m_ready;
    assign step     = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || step;

    assign total      = header_total(length_kind_reg);
    assign mask_start = total - MASK_BYTES;
    assign count_inc  = byte_count_reg + 4'd1;
    assign first_byte = mask_accum_reg[7:0];
    assign opcode     = first_byte[3:0];
    assign len_code   = in_byte_reg[6:0];

    always_comb begin
        byte_count_next   = byte_count_reg;
        length_kind_next  = length_kind_reg;
        length_accum_next = length_accum_reg;
        mask_accum_next   = mask_accum_reg;
        emit              = 1'b0;
        status_next       = STATUS_OK;
        payload_len_next  = '0;
        mask_key_next     = '0;
        header_len_next   = HDR_LEN_SHORT;

        case (byte_count_reg)
            IDX_FIRST: begin
                // Hold the first byte in the mask accumulator until byte two.
                mask_accum_next = {24'd0, in_byte_reg};
                byte_count_next = IDX_SECOND;
            end
            IDX_SECOND: begin
                if (opcode == OP_CLOSE) begin
                    emit        = 1'b1;
                    status_next = STATUS_CLOSE;
                end else if (!first_byte[7]) begin
                    emit        = 1'b1;
                    status_next = STATUS_FRAGMENTED;
                end else if (!in_byte_reg[7]) begin
                    emit        = 1'b1;
                    status_next = STATUS_UNMASKED;
                end else if (opcode != OP_BINARY) begin
                    emit        = 1'b1;
                    status_next = STATUS_NOT_BINARY;
                end else begin
                    if (len_code < LEN_CODE_EXT16) begin
                        length_kind_next  = LEN_KIND_7;
                        length_accum_next = {57'd0, len_code};
                    end else begin
                        length_kind_next  = (len_code == LEN_CODE_EXT16) ?
                                            LEN_KIND_16 : LEN_KIND_64;
                        length_accum_next = '0;
                    end
                    mask_accum_next = '0;
                    byte_count_next = IDX_EXT;
                end
            end
            default: begin
                // Extended length bytes first, then the four mask bytes.
                if (byte_count_reg < mask_start) begin
                    length_accum_next = {length_accum_reg[55:0], in_byte_reg};
                end else begin
                    mask_accum_next = {mask_accum_reg[23:0], in_byte_reg};
                end
                byte_count_next = count_inc;
                if (count_inc >= total) begin
                    emit             = 1'b1;
                    status_next      = STATUS_OK;
                    payload_len_next = length_accum_next;
                    mask_key_next    = mask_accum_next;
                    header_len_next  = total;
                end
            end
        endcase

        // Drop back to the first byte after every result.
        if (emit) begin
            byte_count_next   = IDX_FIRST;
            length_kind_next  = LEN_KIND_7;
            length_accum_next = '0;
            mask_accum_next   = '0;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            byte_count_reg  <= IDX_FIRST;
            length_kind_reg <= LEN_KIND_7;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (step) begin
                byte_count_reg  <= byte_count_next;
                length_kind_reg <= length_kind_next;
                out_valid_reg   <= emit;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_byte_reg <= s_rx_byte;
        end
        if (step) begin
            length_accum_reg <= length_accum_next;
            mask_accum_reg   <= mask_accum_next;
        end
        if (step && emit) begin
            status_reg      <= status_next;
            payload_len_reg <= payload_len_next;
            mask_key_reg    <= mask_key_next;
            header_len_reg  <= header_len_next;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_status         = status_reg;
    assign m_payload_length = payload_len_reg;
    assign m_mask_key       = mask_key_reg;
    assign m_header_length  = header_len_reg;

    // A failed check reports a two-byte header with zero length and key.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && status_reg != STATUS_OK) |->
            (header_len_reg == HDR_LEN_SHORT && payload_len_reg == '0 &&
             mask_key_reg == '0))
        else $error("error result carries header fields");

    // A good header is 6, 8 or 14 bytes long.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && status_reg == STATUS_OK) |->
            (header_len_reg == HDR_LEN_7 || header_len_reg == HDR_LEN_16 ||
             header_len_reg == HDR_LEN_64))
        else $error("bad header length on ok result");

    // Every result restarts the parser at the first byte.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (step && emit) |=> (byte_count_reg == IDX_FIRST))
        else $error("parser did not restart after result");

    // The byte index stays inside the longest header.
    assert property (@(posedge aclk) disable iff (!aresetn)
        byte_count_reg < HDR_LEN_64)
        else $error("byte index past header end");

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

import wshp_pkg::*;

typedef struct packed {
    logic [2:0]  status;
    logic [63:0] payload_length;
    logic [31:0] mask_key;
    logic [3:0]  header_length;
} hdr_result_t;

class header_scoreboard;
    logic [3:0]  byte_idx;
    len_kind_t   kind;
    logic [63:0] len_acc;
    logic [31:0] mask_acc;
    hdr_result_t headers_due[$];
    int          errors;
    int          bytes_seen;
    int          status_tally[8];

    function new();
        errors = 0;
        bytes_seen = 0;
        foreach (status_tally[i]) status_tally[i] = 0;
        restart();
    endfunction

    function void restart();
        byte_idx = IDX_FIRST;
        kind     = LEN_KIND_7;
        len_acc  = '0;
        mask_acc = '0;
    endfunction

    function void close_header(logic [2:0] st, logic [63:0] len, logic [31:0] key,
                               logic [3:0] hdr_len);
        hdr_result_t r;
        r.status         = st;
        r.payload_length = len;
        r.mask_key       = key;
        r.header_length  = hdr_len;
        headers_due.push_back(r);
        restart();
    endfunction

    // Decode one accepted header byte; queue a result when a header ends.
    function void note_byte(logic [7:0] b);
        logic [3:0] op;
        logic [3:0] total;
        bytes_seen++;
        if (byte_idx == IDX_FIRST) begin
            // first byte parks in the mask register until the second arrives
            mask_acc = {24'd0, b};
            byte_idx = IDX_SECOND;
        end else if (byte_idx == IDX_SECOND) begin
            op = mask_acc[3:0];
            if (op == OP_CLOSE)
                close_header(STATUS_CLOSE, '0, '0, HDR_LEN_SHORT);
            else if (!mask_acc[7])
                close_header(STATUS_FRAGMENTED, '0, '0, HDR_LEN_SHORT);
            else if (!b[7])
                close_header(STATUS_UNMASKED, '0, '0, HDR_LEN_SHORT);
            else if (op != OP_BINARY)
                close_header(STATUS_NOT_BINARY, '0, '0, HDR_LEN_SHORT);
            else begin
                if (b[6:0] < LEN_CODE_EXT16) begin
                    kind    = LEN_KIND_7;
                    len_acc = {57'd0, b[6:0]};
                end else begin
                    kind    = (b[6:0] == LEN_CODE_EXT16) ? LEN_KIND_16 : LEN_KIND_64;
                    len_acc = '0;
                end
                mask_acc = '0;
                byte_idx = IDX_EXT;
            end
        end else begin
            case (kind)
                LEN_KIND_7:  total = HDR_LEN_7;
                LEN_KIND_16: total = HDR_LEN_16;
                default:     total = HDR_LEN_64;
            endcase
            if (byte_idx < total - MASK_BYTES)
                len_acc = {len_acc[55:0], b};
            else
                mask_acc = {mask_acc[23:0], b};
            byte_idx = byte_idx + 4'd1;
            if (byte_idx >= total)
                close_header(STATUS_OK, len_acc, mask_acc, total);
        end
    endfunction

    function void check_result(hdr_result_t got);
        hdr_result_t want;
        if (headers_due.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, got status %0d length %h mask %h hdr %0d",
                     $time, got.status, got.payload_length, got.mask_key,
                     got.header_length);
        end else begin
            want = headers_due.pop_front();
            status_tally[want.status]++;
            if (got.status !== want.status) begin
                errors++;
                $display("%0t: status expected %0d got %0d",
                         $time, want.status, got.status);
            end
            if (got.payload_length !== want.payload_length) begin
                errors++;
                $display("%0t: payload_length expected %h got %h",
                         $time, want.payload_length, got.payload_length);
            end
            if (got.mask_key !== want.mask_key) begin
                errors++;
                $display("%0t: mask_key expected %h got %h",
                         $time, want.mask_key, got.mask_key);
            end
            if (got.header_length !== want.header_length) begin
                errors++;
                $display("%0t: header_length expected %0d got %0d",
                         $time, want.header_length, got.header_length);
            end
        end
    endfunction

    function int pending();
        return headers_due.size();
    endfunction
endclass

module tb_top;

    localparam int CLK_HALF       = 5;
    localparam int RESET_CYCLES   = 8;
    localparam int BYTES_PER_PASS = 450;
    localparam int HOLD_CYCLES    = 64;
    localparam int DRAIN_CYCLES   = 8;
    localparam int STALL_LIMIT    = 5000;
    localparam logic [6:0] LEN_CODE_EXT64 = LEN_CODE_EXT16 + 7'd1;

    typedef enum int {
        PASS_RX_SLOW,
        PASS_TX_SLOW,
        PASS_NO_IDLE
    } pass_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_rx_byte;
    logic        m_valid;
    logic        m_ready;
    logic [2:0]  m_status;
    logic [63:0] m_payload_length;
    logic [31:0] m_mask_key;
    logic [3:0]  m_header_length;

    header_scoreboard sb;
    pass_t            pass_now;
    int unsigned      tx_idle_pct;
    int unsigned      rx_idle_pct;
    int               bytes_sent;
    int               stall_cycles;
    bit               hold_done;

    websocket_header_parser dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_rx_byte        (s_rx_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_payload_length (m_payload_length),
        .m_mask_key       (m_mask_key),
        .m_header_length  (m_header_length)
    );

    always #(CLK_HALF) aclk = ~aclk;

    // Mostly a plain byte, sometimes an all-zero or all-one byte.
    function automatic logic [7:0] rand_byte();
        logic [7:0] v;
        case ($urandom_range(7))
            0:       v = 8'h00;
            1:       v = 8'hFF;
            default: v = 8'($urandom);
        endcase
        return v;
    endfunction

    // Offer one byte, idling first at the current sender rate, and hold it
    // until the transfer happens. Note the byte only once it is accepted.
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        do @(posedge aclk); while (!s_ready);
        sb.note_byte(b);
        bytes_sent++;
    endtask

    // Well-formed binary frame header with FIN and MASK set; random reserved
    // bits, length kind, extended length and mask key.
    task automatic send_good_frame();
        int unsigned pick;
        logic [2:0]  rsv;
        logic [6:0]  code;
        int          ext_bytes;
        pick = $urandom_range(99);
        rsv  = 3'($urandom);
        if (pick < 55) begin
            code      = 7'($urandom_range(LEN_CODE_EXT16 - 1, 0));
            ext_bytes = 0;
        end else if (pick < 85) begin
            code      = LEN_CODE_EXT16;
            ext_bytes = 2;
        end else begin
            code      = LEN_CODE_EXT64;
            ext_bytes = 8;
        end
        send_byte({1'b1, rsv, OP_BINARY});
        send_byte({1'b1, code});
        repeat (ext_bytes) send_byte(rand_byte());
        repeat (MASK_BYTES) send_byte(rand_byte());
    endtask

    // Two-byte header that trips one of the checks on purpose.
    task automatic send_bad_header();
        logic [2:0] want;
        logic [2:0] rsv;
        logic [3:0] op;
        want = 3'($urandom_range(STATUS_NOT_BINARY, STATUS_CLOSE));
        rsv  = 3'($urandom);
        do op = 4'($urandom);
        while (op == OP_CLOSE || (want == STATUS_NOT_BINARY && op == OP_BINARY));
        case (want)
            STATUS_CLOSE: begin
                // close wins whatever FIN and MASK say
                send_byte({1'($urandom), rsv, OP_CLOSE});
                send_byte(rand_byte());
            end
            STATUS_FRAGMENTED: begin
                send_byte({1'b0, rsv, op});
                send_byte(rand_byte());
            end
            STATUS_UNMASKED: begin
                send_byte({1'b1, rsv, op});
                send_byte({1'b0, 7'($urandom)});
            end
            default: begin
                send_byte({1'b1, rsv, op});
                send_byte({1'b1, 7'($urandom)});
            end
        endcase
    endtask

    // Three quarters well-formed frames, the rest failing headers and noise
    // that knocks the parser out of frame alignment.
    task automatic send_random_frame();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 75)
            send_good_frame();
        else if (pick < 95)
            send_bad_header();
        else
            repeat ($urandom_range(3, 1)) send_byte(8'($urandom));
    endtask

    task automatic send_directed();
        // close with FIN and MASK both clear: close must still win
        send_byte({1'b0, 3'b000, OP_CLOSE});
        send_byte(8'h00);
        // binary opcode, FIN clear
        send_byte({1'b0, 3'b000, OP_BINARY});
        send_byte(8'h80);
        // FIN set, MASK clear, largest length code
        send_byte({1'b1, 3'b000, OP_BINARY});
        send_byte({1'b0, LEN_CODE_EXT64});
        // text opcode, otherwise valid
        send_byte({1'b1, 3'b000, 4'h1});
        send_byte({1'b1, LEN_CODE_EXT16});
        // largest 7-bit length, zero mask key
        send_byte({1'b1, 3'b000, OP_BINARY});
        send_byte({1'b1, LEN_CODE_EXT16 - 7'd1});
        repeat (MASK_BYTES) send_byte(8'h00);
        // 64-bit length of all ones, bit 63 included, all-ones mask key
        send_byte({1'b1, 3'b111, OP_BINARY});
        send_byte({1'b1, LEN_CODE_EXT64});
        repeat (8) send_byte(8'hFF);
        repeat (MASK_BYTES) send_byte(8'hFF);
    endtask

    task automatic enter_pass(input pass_t p);
        pass_now = p;
        case (p)
            PASS_RX_SLOW: begin tx_idle_pct = 9;  rx_idle_pct = 88; end
            PASS_TX_SLOW: begin tx_idle_pct = 88; rx_idle_pct = 9;  end
            default:      begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
        endcase
    endtask

    // Result side: check every transfer, then pick next cycle's ready.
    // On entering the no-idle pass, hold ready low for a long stretch so the
    // parser backs up and drops s_ready while the sender keeps offering.
    initial begin
        m_ready   <= 1'b0;
        hold_done = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready)
                sb.check_result({m_status, m_payload_length, m_mask_key, m_header_length});
            if (pass_now == PASS_NO_IDLE && !hold_done) begin
                hold_done = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // Count cycles with no transfer on either side; give up past the limit.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles = stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("Timeout: no transfer for %0d cycles, %0d results outstanding",
                         STALL_LIMIT, sb.pending());
                $display("websocket_header_parser test failed");
                $finish;
            end
        end
    end

    initial begin
        sb           = new();
        bytes_sent   = 0;
        enter_pass(PASS_RX_SLOW);
        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_rx_byte <= 8'h00;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        send_directed();
        while (bytes_sent < BYTES_PER_PASS) send_random_frame();
        enter_pass(PASS_TX_SLOW);
        while (bytes_sent < 2 * BYTES_PER_PASS) send_random_frame();
        enter_pass(PASS_NO_IDLE);
        while (bytes_sent < 3 * BYTES_PER_PASS) send_random_frame();
        s_valid <= 1'b0;

        // Drain outstanding headers, then allow for the pipeline latency.
        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Covered %0d header bytes over slow-output, slow-input and no-idle passes,",
                 sb.bytes_seen);
        $display("with results ok %0d, close %0d, fragmented %0d, unmasked %0d, not binary %0d.",
                 sb.status_tally[STATUS_OK], sb.status_tally[STATUS_CLOSE],
                 sb.status_tally[STATUS_FRAGMENTED], sb.status_tally[STATUS_UNMASKED],
                 sb.status_tally[STATUS_NOT_BINARY]);
        if (sb.errors == 0) begin
            $display("websocket_header_parser test passed");
        end else begin
            $display("websocket_header_parser test failed");
        end
        $finish;
    end

endmodule

// ===== websocket_header_parser.f =====
sv/wshp_pkg.sv
sv/websocket_header_parser.sv
tb/tb_top.sv
